### design/hhm_pkg.sv
// hhm_pkg: shared types and constants of the heading-hold motor mixer.
// Used by hhm_wrap_unit, hhm_mix_unit and heading_hold_motor_mix_core.
`timescale 1ns / 1ps

package hhm_pkg;

	// Register index codes of the configuration port.
	typedef enum logic [2:0] {
		REG_DRIFT      = 3'd0,
		REG_GOAL       = 3'd1,
		REG_MODE       = 3'd2,
		REG_BASE_SPEED = 3'd3,
		REG_TRIM_FWD_0 = 3'd4,
		REG_TRIM_FWD_N = 3'd5,
		REG_TRIM_REV_0 = 3'd6,
		REG_TRIM_REV_N = 3'd7
	} cfg_index_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Angle word used by the wrap unit; holds the whole-degree corrected angle.
	localparam int ANG_W      = 18;
	localparam int WRAP_K_W   = 4;
	localparam int WRAP_STEPS = 9;   // multiples of 360 up to 511 turns
	localparam int WRAP_MOD   = 360;
	localparam int HALF_TURN  = 180;

	localparam int YAW_W     = 24;
	localparam int CORR_W    = 35;
	localparam int CHG_W     = 19;
	localparam int HEAD_W    = 9;
	localparam int OFF_W     = 10;
	localparam int SPEED_W   = 11;
	localparam int TRIM_W    = 10;
	localparam int CMP_W     = 12;
	localparam int OFF_SUM_W = 22;
	localparam int MIX_SUM_W = 14;

	localparam int DEADBAND     = 3;
	localparam int OFF_LIMIT    = 400;
	localparam int FORCED_SPEED = 1200;
	localparam int KP_NUM       = 86;
	localparam int KD_GAIN      = 4;
	localparam int CMP_MAX      = 4095;

	// Reciprocals: x/10 = (x*52429)>>19 for 16-bit x, x/54 = (x*1214)>>16 for x <= 180.
	localparam int RECIP_10   = 52429;
	localparam int RECIP_10_S = 19;
	localparam int RECIP_54   = 1214;
	localparam int RECIP_54_S = 16;

	typedef struct packed {
		logic [SPEED_W-1:0]       speed;
		logic signed [OFF_W-1:0]  offset;
		logic signed [TRIM_W-1:0] trim;
	} mix_in_t;

	typedef struct packed {
		logic [CMP_W-1:0] left;
		logic [CMP_W-1:0] right;
	} mix_out_t;

endpackage

### design/hhm_wrap_unit.sv
// hhm_wrap_unit: shared add/compare step that moves an angle toward -180..180.
// Depends on hhm_pkg for widths and constants.
`timescale 1ns / 1ps

module hhm_wrap_unit import hhm_pkg::*; (
	input  logic signed [ANG_W-1:0] value,
	input  logic [WRAP_K_W-1:0]     shift,
	output logic signed [ANG_W-1:0] result
);

	logic signed [ANG_W-1:0] step;
	logic signed [ANG_W-1:0] cand;

	assign step = ANG_W'(WRAP_MOD) << shift;

	// A positive angle takes 360*2^k off if it stays above -180; a negative
	// angle takes it on if it stays below 180. Over k = 8..0 this matches
	// the ceiling count of turns.
	always_comb begin
		cand   = '0;
		result = value;
		if (value > 0) begin
			cand = value - step;
			if (cand >= ANG_W'(-(HALF_TURN - 1)))
				result = cand;
		end else if (value < 0) begin
			cand = value + step;
			if (cand < ANG_W'(HALF_TURN))
				result = cand;
		end
	end

endmodule

### design/hhm_mix_unit.sv
// hhm_mix_unit: forms both motor compare values from speed, offset and trim.
// Depends on hhm_pkg for the mix_in_t and mix_out_t structs.
`timescale 1ns / 1ps

module hhm_mix_unit import hhm_pkg::*; (
	input  mix_in_t  mix_in,
	output mix_out_t mix_out
);

	logic signed [MIX_SUM_W-1:0] speed_s;
	logic signed [MIX_SUM_W-1:0] diff_s;
	logic signed [MIX_SUM_W-1:0] left_s;
	logic signed [MIX_SUM_W-1:0] right_s;

	function automatic logic [CMP_W-1:0] clamp_cmp(input logic signed [MIX_SUM_W-1:0] v);
		if (v < 0)
			return '0;
		else if (v > MIX_SUM_W'(CMP_MAX))
			return CMP_W'(CMP_MAX);
		else
			return v[CMP_W-1:0];
	endfunction

	always_comb begin
		speed_s = $signed({{(MIX_SUM_W - SPEED_W){1'b0}}, mix_in.speed});
		diff_s  = MIX_SUM_W'(mix_in.offset) + MIX_SUM_W'(mix_in.trim);
		left_s  = speed_s + diff_s;
		right_s = speed_s - diff_s;
		if (mix_in.speed == '0) begin
			mix_out.left  = '0;
			mix_out.right = '0;
		end else begin
			mix_out.left  = clamp_cmp(left_s);
			mix_out.right = clamp_cmp(right_s);
		end
	end

endmodule

### design/heading_hold_motor_mix_core.sv
// heading_hold_motor_mix_core: heading-hold steering and two-motor PWM mixer.
// Depends on hhm_pkg, hhm_wrap_unit and hhm_mix_unit.
//
// Usage:
// One yaw sample (signed Q8 degrees) is transferred on the input channel
// when in_valid is high and in_stall is low. The block then works on that
// sample alone and holds in_stall high until it is back in idle. Each
// sample yields exactly one result transfer on the output channel: both
// motor compare values, the wrapped heading and the current steering offset.
// A sample passes the multiply, correction, truncation, change and angle wrap
// steps. With steering active the heading error is then formed, wrapped,
// scaled and summed; with steering disabled or reversing the mix follows at
// once. The angle wrap runs nine add-or-subtract-and-compare steps, one per cycle,
// in the shared wrap unit; that same unit also wraps the heading error.
// The result sits in an output register. If the receiver stalls, the block
// waits in its last step with the next result until the register is free;
// a pending result does not keep the block from taking the next sample.
// Configuration writes take effect at the write edge; the user must make them
// only while the block is idle, which the block does not enforce. Writing the
// base speed clears forced speed. Reset (arst_n low) returns the configuration
// registers to their defaults and the sample counter, previous heading, offset and trim phase to zero.
`timescale 1ns / 1ps

module heading_hold_motor_mix_core import hhm_pkg::*; #(
	parameter int TRIM_CYCLE = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [YAW_W-1:0]  yaw_sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CMP_W-1:0]         left_compare,
	output logic [CMP_W-1:0]         right_compare,
	output logic signed [HEAD_W-1:0] heading_wrapped,
	output logic signed [OFF_W-1:0]  steer_correction
);

	localparam int PH_W = (TRIM_CYCLE > 2) ? $clog2(TRIM_CYCLE) : 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_CORR,
		ST_TRUNC,
		ST_CHG,
		ST_WRAP,
		ST_ERR,
		ST_ERRW,
		ST_SCALE,
		ST_DIV,
		ST_SUM,
		ST_MIX
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0]              drift_q;
	logic signed [HEAD_W-1:0] goal_q;
	logic [1:0]               mode_q;
	logic [SPEED_W-1:0]       base_q;
	logic signed [TRIM_W-1:0] trim_fwd0_q;
	logic signed [TRIM_W-1:0] trim_fwdn_q;
	logic signed [TRIM_W-1:0] trim_rev0_q;
	logic signed [TRIM_W-1:0] trim_revn_q;

	// Persistent control state.
	logic [15:0]              tick_q;
	logic [15:0]              prev_q;
	logic signed [OFF_W-1:0]  steer_q;
	logic [PH_W-1:0]          phase_q;
	logic                     forced_q;

	// Working registers of one sample.
	logic signed [YAW_W-1:0]  yaw_q;
	logic [31:0]              prod_q;
	logic signed [CORR_W-1:0] corr_q;
	logic signed [CORR_W-1:0] delta_q;
	logic signed [ANG_W-1:0]  whole_q;
	logic signed [CHG_W-1:0]  chg_q;
	logic signed [ANG_W-1:0]  val_q;
	logic [WRAP_K_W-1:0]      k_q;
	logic signed [HEAD_W-1:0] head_q;
	logic                     err_neg_q;
	logic                     err_big_q;
	logic [13:0]              m86_q;
	logic [1:0]               q54_q;
	logic [10:0]              q10_q;

	// Output register.
	logic                     out_valid_q;
	mix_out_t                 cmp_q;
	logic signed [HEAD_W-1:0] head_out_q;
	logic signed [OFF_W-1:0]  steer_out_q;

	// Shared wrap step.
	logic [WRAP_K_W-1:0]      wrap_shift;
	logic signed [ANG_W-1:0]  wrap_res;

	assign wrap_shift = (state_q == ST_WRAP) ? k_q : '0;

	hhm_wrap_unit u_wrap (
		.value  (val_q),
		.shift  (wrap_shift),
		.result (wrap_res)
	);

	// Mixer operands.
	mix_in_t  mix_in;
	mix_out_t mix_out;
	logic     speed_zero;

	always_comb begin
		mix_in.speed  = forced_q ? SPEED_W'(FORCED_SPEED) : base_q;
		mix_in.offset = steer_q;
		if (!mode_q[0])
			mix_in.trim = (phase_q == '0) ? trim_fwd0_q : trim_fwdn_q;
		else
			mix_in.trim = (phase_q == '0) ? trim_rev0_q : trim_revn_q;
	end

	assign speed_zero = (mix_in.speed == '0);

	hhm_mix_unit u_mix (
		.mix_in  (mix_in),
		.mix_out (mix_out)
	);

	// Truncation toward zero of Q16 values: a negative value is biased up by
	// 65535 before the whole-degree bits are taken.
	logic signed [CORR_W-1:0] corr_biased;
	logic signed [CORR_W-1:0] delta_raw;
	logic signed [CORR_W-1:0] delta_biased;

	always_comb begin
		corr_biased  = corr_q + (corr_q[CORR_W-1] ? CORR_W'(65535) : CORR_W'(0));
		delta_raw    = corr_q - $signed({{(CORR_W - 32){prev_q[15]}}, prev_q, 16'h0000});
		delta_biased = delta_q + (delta_q[CORR_W-1] ? CORR_W'(65535) : CORR_W'(0));
	end

	// Error magnitude and scaling products.
	logic [7:0]  err_abs;
	logic [14:0] m86_full;
	logic [18:0] q54_full;
	logic [29:0] q10_full;

	always_comb begin
		err_abs  = val_q[ANG_W-1] ? 8'(-val_q) : val_q[7:0];
		m86_full = 15'(err_abs) * 15'(KP_NUM);
		q54_full = 19'(err_abs) * 19'(RECIP_54);
		q10_full = 30'(m86_q) * 30'(RECIP_10);
	end

	// Offset sum and saturation.
	logic [11:0]                 p_mag;
	logic signed [OFF_SUM_W-1:0] p_term;
	logic signed [OFF_SUM_W-1:0] off_sum;
	logic signed [OFF_W-1:0]     off_sat;

	always_comb begin
		p_mag   = 12'(q10_q) + 12'(q54_q);
		p_term  = err_neg_q ? -$signed(OFF_SUM_W'(p_mag)) : $signed(OFF_SUM_W'(p_mag));
		off_sum = p_term + (OFF_SUM_W'(chg_q) * OFF_SUM_W'(KD_GAIN));
		if (off_sum > OFF_SUM_W'(OFF_LIMIT))
			off_sat = OFF_W'(OFF_LIMIT);
		else if (off_sum < OFF_SUM_W'(-OFF_LIMIT))
			off_sat = OFF_W'(-OFF_LIMIT);
		else
			off_sat = off_sum[OFF_W-1:0];
	end

	// Trim phase advance.
	logic [PH_W-1:0] phase_next;

	always_comb begin
		if (({1'b0, phase_q} + (PH_W+1)'(1)) >= (PH_W+1)'(TRIM_CYCLE))
			phase_next = '0;
		else
			phase_next = phase_q + PH_W'(1);
	end

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drift_q     <= 16'd15270;
			goal_q      <= '0;
			mode_q      <= 2'b10;
			base_q      <= '0;
			trim_fwd0_q <= '0;
			trim_fwdn_q <= '0;
			trim_rev0_q <= '0;
			trim_revn_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index_t'(cfg_index))
				REG_DRIFT:      drift_q     <= cfg_data;
				REG_GOAL:       goal_q      <= cfg_data[HEAD_W-1:0];
				REG_MODE:       mode_q      <= cfg_data[1:0];
				REG_BASE_SPEED: base_q      <= cfg_data[SPEED_W-1:0];
				REG_TRIM_FWD_0: trim_fwd0_q <= cfg_data[TRIM_W-1:0];
				REG_TRIM_FWD_N: trim_fwdn_q <= cfg_data[TRIM_W-1:0];
				REG_TRIM_REV_0: trim_rev0_q <= cfg_data[TRIM_W-1:0];
				REG_TRIM_REV_N: trim_revn_q <= cfg_data[TRIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, control state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			prev_q      <= '0;
			steer_q     <= '0;
			phase_q     <= '0;
			forced_q    <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The last step reloads the output register itself.
			if (out_valid_q && !out_stall && (state_q != ST_MIX))
				out_valid_q <= 1'b0;
			if (cfg_wr_en && (cfg_index_t'(cfg_index) == REG_BASE_SPEED))
				forced_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						yaw_q   <= yaw_sample;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= 32'(drift_q) * 32'(tick_q);
					state_q <= ST_CORR;
				end
				ST_CORR: begin
					corr_q  <= CORR_W'($signed({yaw_q, 8'h00})) + $signed({3'b000, prod_q});
					tick_q  <= tick_q + 16'd1;
					state_q <= ST_TRUNC;
				end
				ST_TRUNC: begin
					whole_q <= corr_biased[ANG_W+15:16];
					delta_q <= delta_raw;
					state_q <= ST_CHG;
				end
				ST_CHG: begin
					chg_q   <= delta_biased[CHG_W+15:16];
					prev_q  <= whole_q[15:0];
					val_q   <= whole_q;
					k_q     <= WRAP_K_W'(WRAP_STEPS - 1);
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					val_q <= wrap_res;
					if (k_q == '0) begin
						head_q  <= wrap_res[HEAD_W-1:0];
						state_q <= ST_ERR;
					end else begin
						k_q <= k_q - WRAP_K_W'(1);
					end
				end
				ST_ERR: begin
					// Steering runs only when driving forward with correction on.
					if (mode_q == 2'b00) begin
						val_q   <= ANG_W'(head_q) - ANG_W'(goal_q);
						state_q <= ST_ERRW;
					end else begin
						state_q <= ST_MIX;
					end
				end
				ST_ERRW: begin
					val_q   <= wrap_res;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					err_neg_q <= val_q[ANG_W-1];
					err_big_q <= (err_abs > 8'(DEADBAND));
					m86_q     <= m86_full[13:0];
					q54_q     <= q54_full[RECIP_54_S+1:RECIP_54_S];
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					q10_q   <= q10_full[RECIP_10_S+10:RECIP_10_S];
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (err_big_q) begin
						steer_q  <= off_sat;
						forced_q <= 1'b1;
					end else begin
						steer_q <= '0;
					end
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					if (!out_valid_q || !out_stall) begin
						cmp_q       <= mix_out;
						head_out_q  <= head_q;
						steer_out_q <= steer_q;
						out_valid_q <= 1'b1;
						if (!speed_zero)
							phase_q <= phase_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall         = (state_q != ST_IDLE);
	assign out_valid        = out_valid_q;
	assign left_compare     = cmp_q.left;
	assign right_compare    = cmp_q.right;
	assign heading_wrapped  = head_out_q;
	assign steer_correction = steer_out_q;

	// An accepted sample keeps the input side busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after a sample transfer");

	// The wrapped heading presented is within one half turn.
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heading_wrapped >= -HALF_TURN && heading_wrapped <= HALF_TURN))
		else $error("wrapped heading out of range");

	// The steering offset never leaves its saturation bounds.
	a_steer_range: assert property (@(posedge clk) disable iff (!arst_n)
		(steer_q >= -OFF_LIMIT && steer_q <= OFF_LIMIT))
		else $error("steering offset out of range");

	// The trim phase stays inside the rotation.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, phase_q} < (PH_W+1)'(TRIM_CYCLE)))
		else $error("trim phase out of range");

	// The wrap loop finishes with a heading inside one half turn.
	a_wrap_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRAP && k_q == '0) |->
		(wrap_res >= ANG_W'(-HALF_TURN) && wrap_res <= ANG_W'(HALF_TURN)))
		else $error("angle wrap did not converge");

endmodule

### dv/hhm_checker.sv
// hhm_checker: watches the register port and both sample channels of the heading-hold
// motor mixer, works out the motor commands each yaw sample must produce and compares them.
// Depends on hhm_pkg for widths, register codes and the steering constants.
`timescale 1ns / 1ps

module hhm_checker import hhm_pkg::*; #(
	parameter int TRIM_CYCLE = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic signed [YAW_W-1:0]  yaw_sample,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [CMP_W-1:0]         left_compare,
	input  logic [CMP_W-1:0]         right_compare,
	input  logic signed [HEAD_W-1:0] heading_wrapped,
	input  logic signed [OFF_W-1:0]  steer_correction,
	output int                       fail_count,
	output int                       pending,
	output int                       checked
);

	localparam int KP_DEN         = 10;
	localparam int KI_DIV         = 54;
	localparam int Q16_ONE        = 65536;
	localparam int Q8_TO_Q16      = 256;
	localparam int MODE_REVERSE   = 0;
	localparam int MODE_STEER_OFF = 1;

	typedef struct packed {
		logic [CMP_W-1:0]         left;
		logic [CMP_W-1:0]         right;
		logic signed [HEAD_W-1:0] heading;
		logic signed [OFF_W-1:0]  steer;
	} motor_cmd_t;

	// Register copies.
	logic [15:0]               drift_rate;
	logic signed [HEAD_W-1:0]  goal_deg;
	logic [1:0]                mode_bits;
	logic [SPEED_W-1:0]        base_rate;
	logic signed [TRIM_W-1:0]  trim_fwd0, trim_fwdn, trim_rev0, trim_revn;

	// Mixer state.
	logic [15:0] sample_ctr;
	logic [15:0] last_whole;
	int          offset_now;
	int          phase_now;
	bit          forced_speed;

	motor_cmd_t motor_cmds_due[$];
	motor_cmd_t want;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Advances the mixer state by one sample and returns the commands it yields.
	function automatic motor_cmd_t mix_sample(input logic signed [YAW_W-1:0] yaw);
		longint     corr, whole, head, err, chg, off, speed, trim;
		motor_cmd_t cmd;
		corr  = longint'(yaw) * Q8_TO_Q16 + longint'(drift_rate) * longint'(sample_ctr);
		whole = corr / Q16_ONE;
		sample_ctr = sample_ctr + 16'd1;

		head = whole;
		if (head > HALF_TURN)
			head -= WRAP_MOD * ((head - HALF_TURN + WRAP_MOD - 1) / WRAP_MOD);
		if (head < -HALF_TURN)
			head += WRAP_MOD * ((-HALF_TURN - head + WRAP_MOD - 1) / WRAP_MOD);

		// Steering only updates when it is enabled and the car drives forward.
		if (!mode_bits[MODE_REVERSE] && !mode_bits[MODE_STEER_OFF]) begin
			err = head - longint'(goal_deg);
			chg = (corr - longint'($signed(last_whole)) * Q16_ONE) / Q16_ONE;
			if (err > HALF_TURN)
				err -= WRAP_MOD;
			if (err < -HALF_TURN)
				err += WRAP_MOD;
			if (err > DEADBAND || err < -DEADBAND) begin
				off = (err * KP_NUM) / KP_DEN + err / KI_DIV + chg * KD_GAIN;
				offset_now = int'(clip(off, -OFF_LIMIT, OFF_LIMIT));
				forced_speed = 1'b1;
			end else begin
				offset_now = 0;
			end
		end
		last_whole = whole[15:0];

		speed = forced_speed ? longint'(FORCED_SPEED) : longint'(base_rate);
		if (speed == 0) begin
			cmd.left  = '0;
			cmd.right = '0;
		end else begin
			if (!mode_bits[MODE_REVERSE])
				trim = (phase_now == 0) ? longint'(trim_fwd0) : longint'(trim_fwdn);
			else
				trim = (phase_now == 0) ? longint'(trim_rev0) : longint'(trim_revn);
			cmd.left  = CMP_W'(clip(speed + offset_now + trim, 0, CMP_MAX));
			cmd.right = CMP_W'(clip(speed - offset_now - trim, 0, CMP_MAX));
			phase_now = (phase_now + 1 >= TRIM_CYCLE) ? 0 : phase_now + 1;
		end
		cmd.heading = HEAD_W'(head);
		cmd.steer   = OFF_W'(offset_now);
		return cmd;
	endfunction

	task automatic check_field(input string name, input logic signed [15:0] exp_v,
			input logic signed [15:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drift_rate   = 16'd15270;
			goal_deg     = '0;
			mode_bits    = 2'b10;
			base_rate    = '0;
			trim_fwd0    = '0;
			trim_fwdn    = '0;
			trim_rev0    = '0;
			trim_revn    = '0;
			sample_ctr   = '0;
			last_whole   = '0;
			offset_now   = 0;
			phase_now    = 0;
			forced_speed = 1'b0;
			fail_count   = 0;
			checked      = 0;
			motor_cmds_due.delete();
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index_t'(cfg_index))
					REG_DRIFT:      drift_rate = cfg_data;
					REG_GOAL:       goal_deg = cfg_data[HEAD_W-1:0];
					REG_MODE:       mode_bits = cfg_data[1:0];
					REG_BASE_SPEED: begin
						base_rate = cfg_data[SPEED_W-1:0];
						forced_speed = 1'b0;
					end
					REG_TRIM_FWD_0: trim_fwd0 = cfg_data[TRIM_W-1:0];
					REG_TRIM_FWD_N: trim_fwdn = cfg_data[TRIM_W-1:0];
					REG_TRIM_REV_0: trim_rev0 = cfg_data[TRIM_W-1:0];
					REG_TRIM_REV_N: trim_revn = cfg_data[TRIM_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				motor_cmds_due.push_back(mix_sample(yaw_sample));
			if (out_valid && !out_stall) begin
				if (motor_cmds_due.size() == 0) begin
					$error("result transfer with no yaw sample outstanding");
					fail_count++;
				end else begin
					want = motor_cmds_due.pop_front();
					check_field("left_compare", want.left, left_compare);
					check_field("right_compare", want.right, right_compare);
					check_field("heading_wrapped", want.heading, heading_wrapped);
					check_field("steer_correction", want.steer, steer_correction);
					checked++;
				end
			end
			pending <= motor_cmds_due.size();
		end
	end

endmodule

### dv/tb_top.sv
// tb_top: stimulus and verdict for heading_hold_motor_mix_core.
// Depends on hhm_pkg, the block itself and hhm_checker, which predicts and compares results.
`timescale 1ns / 1ps

module tb_top;
	import hhm_pkg::*;

	localparam int TRIM_CYCLE     = 3;
	localparam int YAW_MAX        = 8388607;
	localparam int YAW_MIN        = -8388608;
	localparam int Q8             = 256;
	localparam int IDLE_PCT       = 30;
	localparam int RANDOM_PHASES  = 12;
	localparam int SAMPLES_PHASE  = 50;
	localparam int CALM_PHASE     = 4;
	localparam int NUM_REGS       = 8;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [YAW_W-1:0]  yaw_sample = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [CMP_W-1:0]         left_compare;
	logic [CMP_W-1:0]         right_compare;
	logic signed [HEAD_W-1:0] heading_wrapped;
	logic signed [OFF_W-1:0]  steer_correction;

	int fail_count;
	int pending;
	int checked;

	// When calm is set, neither the sender nor the receiver inserts any idle cycles.
	bit     calm = 1'b0;
	int     samples_sent = 0;
	int     settings_applied = 0;
	int     cur_drift = 15270;
	int     cur_goal = 0;
	longint heading_walk = 0;
	int     reg_val [NUM_REGS];

	heading_hold_motor_mix_core #(
		.TRIM_CYCLE(TRIM_CYCLE)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.yaw_sample       (yaw_sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.left_compare     (left_compare),
		.right_compare    (right_compare),
		.heading_wrapped  (heading_wrapped),
		.steer_correction (steer_correction)
	);

	hhm_checker #(
		.TRIM_CYCLE(TRIM_CYCLE)
	) checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.yaw_sample       (yaw_sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.left_compare     (left_compare),
		.right_compare    (right_compare),
		.heading_wrapped  (heading_wrapped),
		.steer_correction (steer_correction),
		.fail_count       (fail_count),
		.pending          (pending),
		.checked          (checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The receiver stalls at random, IDLE_PCT percent of the time, except during the calm phase.
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// Puts one register write on the port. The caller lowers the write enable after the
	// last write of a group, so back-to-back writes keep it high without a glitch.
	task automatic write_reg(input cfg_index_t idx, input int value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		if (idx == REG_DRIFT)
			cur_drift = value;
		if (idx == REG_GOAL)
			cur_goal = value;
	endtask

	// Holds back new samples until every outstanding result has been transferred
	// and the block has dropped its input stall, then lets it settle.
	// The first edge lets the checker count a transfer taken at the current edge.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		while (in_stall)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the registers selected by the mask from reg_val while the block is idle.
	task automatic apply_settings(input bit [NUM_REGS-1:0] which);
		drain_results();
		for (int i = 0; i < NUM_REGS; i++) begin
			if (which[i])
				write_reg(cfg_index_t'(i), reg_val[i]);
		end
		cfg_wr_en <= 1'b0;
		settings_applied++;
	endtask

	// Presents one yaw sample and waits for its transfer. Valid stays high after the
	// transfer so that a following sample can go out without a dead cycle.
	task automatic send_yaw(input longint value);
		longint v;
		v = value;
		if (v > YAW_MAX)
			v = YAW_MAX;
		if (v < YAW_MIN)
			v = YAW_MIN;
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		yaw_sample <= v[YAW_W-1:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		samples_sent++;
	endtask

	function automatic int pick_extreme(input int lo, input int hi);
		int sel;
		sel = $urandom_range(9);
		if (sel == 0)
			return lo;
		if (sel == 1)
			return hi;
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// Mostly a wandering heading or one near the goal, the accumulated drift taken back out,
	// so the corrected angle stays near the goal and the deadband and change term
	// see realistic values. The rest is full-range noise and the field extremes.
	function automatic longint pick_yaw();
		int                      sel;
		longint                  drift_q8;
		logic signed [YAW_W-1:0] noise;
		sel = $urandom_range(99);
		drift_q8 = (longint'(cur_drift) * samples_sent) / Q8;
		if (sel < 45) begin
			heading_walk += longint'($urandom_range(1536)) - 768;
			if (heading_walk > 200 * Q8 || heading_walk < -200 * Q8)
				heading_walk = longint'(cur_goal) * Q8;
			return heading_walk - drift_q8;
		end
		if (sel < 75) begin
			heading_walk = longint'(cur_goal + int'($urandom_range(12)) - 6) * Q8
				+ longint'($urandom_range(Q8 - 1));
			return heading_walk - drift_q8;
		end
		if (sel < 90) begin
			noise = YAW_W'($urandom);
			return noise;
		end
		case ($urandom_range(3))
			0: return YAW_MIN;
			1: return YAW_MAX;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: steering disabled and zero base speed, so both motors stay off
		// while the drift correction and the angle wrap still act on the heading.
		send_yaw(0);
		send_yaw(YAW_MAX);
		send_yaw(YAW_MIN);

		// Steering active, no drift, trims at both ends of their range.
		reg_val = '{0, 0, 0, 1000, 500, -500, -500, 500};
		apply_settings('1);
		send_yaw(0);
		send_yaw(3 * Q8);                 // edge of the deadband
		send_yaw(-(3 * Q8 + Q8 - 1));     // truncates back into the deadband
		send_yaw(4 * Q8);                 // just outside, forces the speed
		send_yaw(-4 * Q8);
		send_yaw(100 * Q8);               // large error and change, saturates
		send_yaw(-Q8 / 2);                // negative fraction truncates to zero
		send_yaw(181 * Q8);               // wraps to the other side
		send_yaw(-181 * Q8);
		send_yaw(540 * Q8);               // one whole turn removed, lands on the half turn

		// Goal near the half turn, so the heading error itself has to wrap.
		reg_val[REG_GOAL] = 170;
		apply_settings(NUM_REGS'(1) << REG_GOAL);
		send_yaw(-170 * Q8);
		send_yaw(175 * Q8);

		// Reversing and steering-off both hold the last offset.
		reg_val[REG_MODE] = 1;
		apply_settings(NUM_REGS'(1) << REG_MODE);
		send_yaw(10 * Q8);
		reg_val[REG_MODE] = 3;
		apply_settings(NUM_REGS'(1) << REG_MODE);
		send_yaw(-10 * Q8);

		// A base speed write drops forced speed; zero stops both motors.
		reg_val[REG_BASE_SPEED] = 0;
		apply_settings(NUM_REGS'(1) << REG_BASE_SPEED);
		send_yaw(50 * Q8);

		// Largest drift, goal at the negative half turn, top base speed.
		reg_val = '{65535, -180, 0, 2000, 0, 0, 0, 0};
		apply_settings('1);
		send_yaw(30 * Q8);
		send_yaw(-30 * Q8);

		// Low speed with full negative trim drives one compare value below zero.
		reg_val = '{0, 0, 0, 100, -500, -500, 500, 500};
		apply_settings('1);
		send_yaw(0);

		// Random phases, each under new settings. The first writes every register;
		// later ones rewrite a random subset so forced speed can carry across phases.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			reg_val[REG_DRIFT]      = pick_extreme(0, 65535);
			reg_val[REG_GOAL]       = pick_extreme(-HALF_TURN, HALF_TURN);
			reg_val[REG_MODE]       = $urandom_range(1) ? 0 : int'($urandom_range(3));
			reg_val[REG_BASE_SPEED] = pick_extreme(0, 2000);
			reg_val[REG_TRIM_FWD_0] = pick_extreme(-500, 500);
			reg_val[REG_TRIM_FWD_N] = pick_extreme(-500, 500);
			reg_val[REG_TRIM_REV_0] = pick_extreme(-500, 500);
			reg_val[REG_TRIM_REV_N] = pick_extreme(-500, 500);
			apply_settings((phase == 0) ? '1 : NUM_REGS'($urandom));
			calm = (phase == CALM_PHASE);
			heading_walk = longint'(cur_goal) * Q8;
			repeat (SAMPLES_PHASE) send_yaw(pick_yaw());
		end
		calm = 1'b0;

		drain_results();
		repeat (30) @(posedge clk);

		$display("tb_top: %0d yaw samples under %0d register settings, %0d results compared",
			samples_sent, settings_applied, checked);
		$display("tb_top: covered all drive modes, stop, deadband, angle and error wrap, trims");
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
